### hdl/tcx_pkg.sv
// ----------------------------------------------------------------------------
// tcx_pkg
// Shared constants, opcodes, status codes and pipeline types of the execute
// unit.
// ----------------------------------------------------------------------------
package tcx_pkg;

   localparam int WORD_BITS           = 16;
   localparam int CMD_BITS            = 5;
   localparam int STATUS_BITS         = 2;
   localparam int STACK_DEPTH_DEFAULT = 64;
   localparam logic [WORD_BITS-1:0] PROGRAM_LINES_RESET = 16'hFFFF;

   localparam logic [CMD_BITS-1:0] OP_NEG  = 5'd1;
   localparam logic [CMD_BITS-1:0] OP_DEC  = 5'd2;
   localparam logic [CMD_BITS-1:0] OP_INC  = 5'd3;
   localparam logic [CMD_BITS-1:0] OP_NOT  = 5'd4;
   localparam logic [CMD_BITS-1:0] OP_RCL  = 5'd5;
   localparam logic [CMD_BITS-1:0] OP_RCR  = 5'd6;
   localparam logic [CMD_BITS-1:0] OP_POP  = 5'd7;
   localparam logic [CMD_BITS-1:0] OP_PUSH = 5'd8;
   localparam logic [CMD_BITS-1:0] OP_ADD  = 5'd9;
   localparam logic [CMD_BITS-1:0] OP_SUB  = 5'd10;
   localparam logic [CMD_BITS-1:0] OP_ADC  = 5'd11;
   localparam logic [CMD_BITS-1:0] OP_SBB  = 5'd12;
   localparam logic [CMD_BITS-1:0] OP_MOV  = 5'd13;
   localparam logic [CMD_BITS-1:0] OP_CMP  = 5'd14;
   localparam logic [CMD_BITS-1:0] OP_AND  = 5'd15;
   localparam logic [CMD_BITS-1:0] OP_OR   = 5'd16;
   localparam logic [CMD_BITS-1:0] OP_CLC  = 5'd17;
   localparam logic [CMD_BITS-1:0] OP_STC  = 5'd18;
   localparam logic [CMD_BITS-1:0] OP_CMC  = 5'd19;
   localparam logic [CMD_BITS-1:0] OP_JMP  = 5'd20;
   localparam logic [CMD_BITS-1:0] OP_JZ   = 5'd21;
   localparam logic [CMD_BITS-1:0] OP_JNZ  = 5'd22;
   localparam logic [CMD_BITS-1:0] OP_JC   = 5'd23;
   localparam logic [CMD_BITS-1:0] OP_JNC  = 5'd24;
   localparam logic [CMD_BITS-1:0] OP_LOOP = 5'd25;
   localparam logic [CMD_BITS-1:0] OP_CALL = 5'd26;
   localparam logic [CMD_BITS-1:0] OP_RET  = 5'd27;

   localparam logic [STATUS_BITS-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_EMPTY   = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_OUTSIDE = 2'd2;
   localparam logic [STATUS_BITS-1:0] ST_FULL    = 2'd3;

   typedef struct packed {
      logic [WORD_BITS-1:0]   write_value;
      logic                   write_enable;
      logic [WORD_BITS-1:0]   count_out;
      logic                   count_write;
      logic [WORD_BITS-1:0]   next_line;
      logic [WORD_BITS-1:0]   current_line;
      logic                   carry;
      logic                   zero;
      logic [STATUS_BITS-1:0] status;
      logic                   check_range;
      logic                   sel_pop;
      logic                   sel_ret;
   } tcx_pipe_type;

   typedef struct packed {
      logic [WORD_BITS-1:0]   write_value;
      logic                   write_enable;
      logic [WORD_BITS-1:0]   count_out;
      logic                   count_write;
      logic [WORD_BITS-1:0]   next_line;
      logic                   carry;
      logic                   zero;
      logic [STATUS_BITS-1:0] status;
   } tcx_result_type;

endpackage

### hdl/tcx_req_if.sv
// ----------------------------------------------------------------------------
// tcx_req_if
// Instruction channel: opcode, fetched operands, count, target and line.
// ----------------------------------------------------------------------------
interface tcx_req_if;
   import tcx_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CMD_BITS-1:0]  cmd;
   logic [WORD_BITS-1:0] operand_a;
   logic [WORD_BITS-1:0] operand_b;
   logic [WORD_BITS-1:0] count_value;
   logic [WORD_BITS-1:0] jump_target;
   logic [WORD_BITS-1:0] current_line;

   modport source (
      output valid, cmd, operand_a, operand_b, count_value, jump_target, current_line,
      input  ready
   );

   modport sink (
      input  valid, cmd, operand_a, operand_b, count_value, jump_target, current_line,
      output ready
   );
endinterface

### hdl/tcx_rsp_if.sv
// ----------------------------------------------------------------------------
// tcx_rsp_if
// Result channel: write-back, count update, next line, flags and status.
// ----------------------------------------------------------------------------
interface tcx_rsp_if;
   import tcx_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [WORD_BITS-1:0]   write_value;
   logic                   write_enable;
   logic [WORD_BITS-1:0]   count_out;
   logic                   count_write;
   logic [WORD_BITS-1:0]   next_line;
   logic                   carry_out;
   logic                   zero_out;
   logic [STATUS_BITS-1:0] status;

   modport source (
      output valid, write_value, write_enable, count_out, count_write, next_line,
             carry_out, zero_out, status,
      input  ready
   );

   modport sink (
      input  valid, write_value, write_enable, count_out, count_write, next_line,
             carry_out, zero_out, status,
      output ready
   );
endinterface

### hdl/tcx_ram.sv
// ----------------------------------------------------------------------------
// tcx_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tcx_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/tcx_issue.sv
// ----------------------------------------------------------------------------
// tcx_issue
// Decode and ALU stage: flags, stack level, stack RAM access and the
// first pipeline register.
// ----------------------------------------------------------------------------
module tcx_issue #(
   parameter int STACK_DEPTH = tcx_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   tcx_req_if.sink                           req,
   input  logic [tcx_pkg::WORD_BITS-1:0]     program_lines,
   input  logic                              s1_take,
   output logic                              s1_valid,
   output tcx_pkg::tcx_pipe_type             s1_data,
   output logic                              ram_wr_en,
   output logic [$clog2(STACK_DEPTH)-1:0]    ram_wr_addr,
   output logic [tcx_pkg::WORD_BITS-1:0]     ram_wr_data,
   output logic                              ram_rd_en,
   output logic [$clog2(STACK_DEPTH)-1:0]    ram_rd_addr
);
   import tcx_pkg::*;

   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int LVL_W  = $clog2(STACK_DEPTH + 1);

   logic                 carry_ff, carry_in;
   logic                 zero_ff, zero_in;
   logic [LVL_W-1:0]     level_ff, level_in;
   logic                 s1_valid_ff;
   tcx_pipe_type         s1_ff, s1_in;

   logic                 accept;
   logic [WORD_BITS:0]   line_inc;
   logic [WORD_BITS-1:0] next_seq;
   logic [WORD_BITS:0]   add_sum;
   logic [WORD_BITS:0]   sub_rhs;
   logic [WORD_BITS+1:0] sub_diff;
   logic [WORD_BITS-1:0] neg_r, dec_r, inc_r, and_r, or_r, loop_cnt;
   logic [LVL_W-1:0]     level_dec;
   logic                 is_end, pop_op, push_op, empty, full;
   logic                 push_go, pop_go;

   assign req.ready = !s1_valid_ff || s1_take;
   assign accept    = req.valid && req.ready;

   assign line_inc  = {1'b0, req.current_line} + (WORD_BITS+1)'(1);
   assign next_seq  = line_inc[WORD_BITS-1:0];
   assign is_end    = line_inc >= {1'b0, program_lines};
   assign pop_op    = (req.cmd == OP_POP) || (req.cmd == OP_RET);
   assign push_op   = (req.cmd == OP_PUSH) || (req.cmd == OP_CALL);
   assign empty     = level_ff == '0;
   assign full      = level_ff == LVL_W'(STACK_DEPTH);
   assign level_dec = level_ff - LVL_W'(1);

   assign add_sum  = {1'b0, req.operand_a} + {1'b0, req.operand_b}
                   + (WORD_BITS+1)'((req.cmd == OP_ADC) && carry_ff);
   assign sub_rhs  = {1'b0, req.operand_b} + (WORD_BITS+1)'((req.cmd == OP_SBB) && carry_ff);
   assign sub_diff = {2'b00, req.operand_a} - {1'b0, sub_rhs};
   assign neg_r    = '0 - req.operand_a;
   assign dec_r    = req.operand_a - WORD_BITS'(1);
   assign inc_r    = req.operand_a + WORD_BITS'(1);
   assign and_r    = req.operand_a & req.operand_b;
   assign or_r     = req.operand_a | req.operand_b;
   assign loop_cnt = req.count_value - WORD_BITS'(1);

   assign push_go = !is_end && push_op && !full;
   assign pop_go  = !is_end && pop_op && !empty;

   always_comb begin
      carry_in            = carry_ff;
      zero_in             = zero_ff;
      level_in            = level_ff;
      s1_in.write_value   = '0;
      s1_in.write_enable  = 1'b0;
      s1_in.count_out     = '0;
      s1_in.count_write   = 1'b0;
      s1_in.next_line     = next_seq;
      s1_in.current_line  = req.current_line;
      s1_in.status        = ST_OK;
      s1_in.check_range   = 1'b1;
      s1_in.sel_pop       = 1'b0;
      s1_in.sel_ret       = 1'b0;

      priority if (is_end) begin
         s1_in.next_line   = WORD_BITS'(1);
         s1_in.check_range = 1'b0;
      end else if (pop_op && empty) begin
         s1_in.next_line   = WORD_BITS'(1);
         s1_in.status      = ST_EMPTY;
         s1_in.check_range = 1'b0;
      end else if (push_op && full) begin
         s1_in.next_line   = WORD_BITS'(1);
         s1_in.status      = ST_FULL;
         s1_in.check_range = 1'b0;
      end else begin
         unique case (req.cmd)
            OP_NEG: begin
               zero_in            = neg_r == '0;
               s1_in.write_value  = neg_r;
               s1_in.write_enable = 1'b1;
            end
            OP_DEC: begin
               zero_in            = dec_r == '0;
               s1_in.write_value  = dec_r;
               s1_in.write_enable = 1'b1;
            end
            OP_INC: begin
               zero_in            = inc_r == '0;
               s1_in.write_value  = inc_r;
               s1_in.write_enable = 1'b1;
            end
            OP_NOT: begin
               s1_in.write_value  = ~req.operand_a;
               s1_in.write_enable = 1'b1;
            end
            OP_RCL: begin
               s1_in.write_value  = {req.operand_a[WORD_BITS-2:0], carry_ff};
               carry_in           = req.operand_a[WORD_BITS-1];
               s1_in.write_enable = 1'b1;
            end
            OP_RCR: begin
               s1_in.write_value  = {carry_ff, req.operand_a[WORD_BITS-1:1]};
               carry_in           = req.operand_a[0];
               s1_in.write_enable = 1'b1;
            end
            OP_POP: begin
               level_in           = level_dec;
               s1_in.write_enable = 1'b1;
               s1_in.sel_pop      = 1'b1;
            end
            OP_PUSH: begin
               level_in = level_ff + LVL_W'(1);
            end
            OP_ADD, OP_ADC: begin
               carry_in           = add_sum[WORD_BITS];
               zero_in            = add_sum[WORD_BITS-1:0] == '0;
               s1_in.write_value  = add_sum[WORD_BITS-1:0];
               s1_in.write_enable = 1'b1;
            end
            OP_SUB, OP_SBB, OP_CMP: begin
               carry_in           = sub_diff[WORD_BITS+1];
               zero_in            = sub_diff[WORD_BITS-1:0] == '0;
               if (req.cmd != OP_CMP) begin
                  s1_in.write_value  = sub_diff[WORD_BITS-1:0];
                  s1_in.write_enable = 1'b1;
               end
            end
            OP_MOV: begin
               s1_in.write_value  = req.operand_b;
               s1_in.write_enable = 1'b1;
            end
            OP_AND: begin
               carry_in           = 1'b0;
               zero_in            = and_r == '0;
               s1_in.write_value  = and_r;
               s1_in.write_enable = 1'b1;
            end
            OP_OR: begin
               carry_in           = 1'b0;
               zero_in            = or_r == '0;
               s1_in.write_value  = or_r;
               s1_in.write_enable = 1'b1;
            end
            OP_CLC: carry_in = 1'b0;
            OP_STC: carry_in = 1'b1;
            OP_CMC: carry_in = !carry_ff;
            OP_JMP: s1_in.next_line = req.jump_target;
            OP_JZ: begin
               if (zero_ff) s1_in.next_line = req.jump_target;
            end
            OP_JNZ: begin
               if (!zero_ff) s1_in.next_line = req.jump_target;
            end
            OP_JC: begin
               if (carry_ff) s1_in.next_line = req.jump_target;
            end
            OP_JNC: begin
               if (!carry_ff) s1_in.next_line = req.jump_target;
            end
            OP_LOOP: begin
               s1_in.count_out   = loop_cnt;
               s1_in.count_write = 1'b1;
               if (loop_cnt != '0) s1_in.next_line = req.jump_target;
            end
            OP_CALL: begin
               level_in        = level_ff + LVL_W'(1);
               s1_in.next_line = req.jump_target;
            end
            OP_RET: begin
               level_in      = level_dec;
               s1_in.sel_ret = 1'b1;
            end
            default: begin
            end
         endcase
      end

      s1_in.carry = carry_in;
      s1_in.zero  = zero_in;
   end

   assign ram_wr_en   = accept && push_go;
   assign ram_wr_addr = level_ff[ADDR_W-1:0];
   assign ram_wr_data = (req.cmd == OP_CALL) ? next_seq : req.operand_a;
   assign ram_rd_en   = accept && pop_go;
   assign ram_rd_addr = level_dec[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         carry_ff    <= 1'b0;
         zero_ff     <= 1'b0;
         level_ff    <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            carry_ff <= carry_in;
            zero_ff  <= zero_in;
            level_ff <= level_in;
         end
         if (req.ready) begin
            s1_valid_ff <= req.valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1_data  = s1_ff;

endmodule

### hdl/tcx_retire.sv
// ----------------------------------------------------------------------------
// tcx_retire
// Merges popped stack data, checks the next line against the program and
// holds the result register.
// ----------------------------------------------------------------------------
module tcx_retire (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          s1_valid,
   input  tcx_pkg::tcx_pipe_type         s1_data,
   input  logic [tcx_pkg::WORD_BITS-1:0] ram_rd_data,
   input  logic [tcx_pkg::WORD_BITS-1:0] program_lines,
   output logic                          s1_take,
   tcx_rsp_if.source                     rsp
);
   import tcx_pkg::*;

   logic                 s2_valid_ff;
   tcx_result_type       s2_ff, s2_in;
   logic [WORD_BITS-1:0] next_sel;
   logic                 outside;

   assign s1_take  = s1_valid && (!s2_valid_ff || rsp.ready);
   assign next_sel = s1_data.sel_ret ? ram_rd_data : s1_data.next_line;
   assign outside  = (next_sel >= program_lines) || (next_sel == '0);

   always_comb begin
      s2_in.write_value  = s1_data.sel_pop ? ram_rd_data : s1_data.write_value;
      s2_in.write_enable = s1_data.write_enable;
      s2_in.count_out    = s1_data.count_out;
      s2_in.count_write  = s1_data.count_write;
      s2_in.carry        = s1_data.carry;
      s2_in.zero         = s1_data.zero;
      if (s1_data.check_range && outside) begin
         s2_in.next_line = s1_data.current_line;
         s2_in.status    = ST_OUTSIDE;
      end else begin
         s2_in.next_line = next_sel;
         s2_in.status    = s1_data.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s1_take) begin
         s2_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         s2_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_take) begin
         s2_ff <= s2_in;
      end
   end

   assign rsp.valid        = s2_valid_ff;
   assign rsp.write_value  = s2_ff.write_value;
   assign rsp.write_enable = s2_ff.write_enable;
   assign rsp.count_out    = s2_ff.count_out;
   assign rsp.count_write  = s2_ff.count_write;
   assign rsp.next_line    = s2_ff.next_line;
   assign rsp.carry_out    = s2_ff.carry;
   assign rsp.zero_out     = s2_ff.zero;
   assign rsp.status       = s2_ff.status;

endmodule

### hdl/teaching_cpu_execute_unit.sv
// ----------------------------------------------------------------------------
// teaching_cpu_execute_unit
// Execute unit of a 16-bit teaching machine with carry/zero flags and a
// bounded call/data stack held in a synchronous RAM.
// ----------------------------------------------------------------------------
// One instruction is accepted per cycle while the rsp channel is ready; its
// result passes the s1 and s2 registers to rsp; throughput is one transaction
// per clock. The stack RAM has one write and one read port; each instruction
// makes at most one stack access at acceptance, and the popped word arrives in
// the next cycle, where it forms the POP write-back or the RET return line.
// Flags and stack level update at acceptance, so dependent instructions issue
// back to back without stalls. The user must write program_lines through
// csr_wr_en / csr_wr_data only while no transaction is in flight; this is not
// enforced by the block. The stack needs no clearing pass after reset.
module teaching_cpu_execute_unit #(
   parameter int STACK_DEPTH = tcx_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   tcx_req_if.sink                       req_chan,
   tcx_rsp_if.source                     rsp_chan,
   input  logic                          csr_wr_en,
   input  logic [tcx_pkg::WORD_BITS-1:0] csr_wr_data
);
   import tcx_pkg::*;

   localparam int ADDR_W = $clog2(STACK_DEPTH);

   logic [WORD_BITS-1:0] program_lines_ff;
   logic                 s1_valid;
   logic                 s1_take;
   tcx_pipe_type         s1_data;
   logic                 ram_wr_en;
   logic [ADDR_W-1:0]    ram_wr_addr;
   logic [WORD_BITS-1:0] ram_wr_data;
   logic                 ram_rd_en;
   logic [ADDR_W-1:0]    ram_rd_addr;
   logic [WORD_BITS-1:0] ram_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         program_lines_ff <= PROGRAM_LINES_RESET;
      end else if (csr_wr_en) begin
         program_lines_ff <= csr_wr_data;
      end
   end

   tcx_issue #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_issue (
      .clock         (clock),
      .reset         (reset),
      .req           (req_chan),
      .program_lines (program_lines_ff),
      .s1_take       (s1_take),
      .s1_valid      (s1_valid),
      .s1_data       (s1_data),
      .ram_wr_en     (ram_wr_en),
      .ram_wr_addr   (ram_wr_addr),
      .ram_wr_data   (ram_wr_data),
      .ram_rd_en     (ram_rd_en),
      .ram_rd_addr   (ram_rd_addr)
   );

   tcx_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   tcx_retire u_retire (
      .clock         (clock),
      .reset         (reset),
      .s1_valid      (s1_valid),
      .s1_data       (s1_data),
      .ram_rd_data   (ram_rd_data),
      .program_lines (program_lines_ff),
      .s1_take       (s1_take),
      .rsp           (rsp_chan)
   );

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the teaching machine execute unit. A driver feeds
// instruction transactions from a pending queue and predicts each result at
// acceptance. The prediction covers the flags, the stack and the program
// length. A monitor compares every result transaction field by field. Both
// channels idle at random. The run covers several program lengths, stack
// overflow and underflow, jumps outside the program and end of program.
// ----------------------------------------------------------------------------
module testbench;
   import tcx_pkg::*;

   localparam int STACK_SLOTS   = STACK_DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 6;

   typedef struct {
      logic [CMD_BITS-1:0]  cmd;
      logic [WORD_BITS-1:0] a;
      logic [WORD_BITS-1:0] b;
      logic [WORD_BITS-1:0] cnt;
      logic [WORD_BITS-1:0] tgt;
      logic [WORD_BITS-1:0] line;
   } instr_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic [WORD_BITS-1:0] csr_wr_data;

   tcx_req_if req_if ();
   tcx_rsp_if rsp_if ();

   teaching_cpu_execute_unit #(
      .STACK_DEPTH (STACK_SLOTS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // predictor state
   logic [WORD_BITS-1:0] prog_lines;
   logic                 flag_c;
   logic                 flag_z;
   logic [WORD_BITS-1:0] stack_mem [STACK_SLOTS];
   int                   stack_top;
   int                   stack_peak;

   instr_type      pending_instrs[$];
   tcx_result_type expected_results[$];
   instr_type      cur_instr;

   int issued;
   int accepted;
   int checked;
   int err_count;
   int cycle_count;
   int settings_run;
   int status_seen [4];
   int req_gap;
   int req_quiet;
   int rsp_stall;
   int rsp_quiet;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic report_error(input string msg);
      $display("ERROR cycle %0d: %s", cycle_count, msg);
      err_count++;
   endtask

   task automatic check_field(input string name, input logic [WORD_BITS-1:0] got,
                              input logic [WORD_BITS-1:0] want);
      if (got !== want)
         report_error($sformatf("result %0d %s got %h expected %h", checked, name, got, want));
   endtask

   function automatic int pick_gap(inout int quiet);
      int r;
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         quiet = $urandom_range(20, 60);
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 80) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 50);
   endfunction

   function automatic tcx_result_type execute_instr(input instr_type it);
      tcx_result_type       res;
      logic [WORD_BITS-1:0] nxt;
      logic [WORD_BITS-1:0] r;
      logic [WORD_BITS:0]   wide;
      logic [WORD_BITS:0]   sub;
      res = '0;
      nxt = it.line + 16'd1;
      res.carry = flag_c;
      res.zero  = flag_z;
      res.status = ST_OK;
      if ({1'b0, it.line} + 17'd1 >= {1'b0, prog_lines}) begin
         res.next_line = 16'd1;
         return res;
      end
      if ((it.cmd == OP_POP || it.cmd == OP_RET) && stack_top == 0) begin
         res.next_line = 16'd1;
         res.status = ST_EMPTY;
         return res;
      end
      if ((it.cmd == OP_PUSH || it.cmd == OP_CALL) && stack_top >= STACK_SLOTS) begin
         res.next_line = 16'd1;
         res.status = ST_FULL;
         return res;
      end
      case (it.cmd)
         OP_NEG, OP_DEC, OP_INC: begin
            if (it.cmd == OP_NEG) r = 16'd0 - it.a;
            else if (it.cmd == OP_DEC) r = it.a - 16'd1;
            else r = it.a + 16'd1;
            flag_z = (r == 16'd0);
            res.write_value = r;
            res.write_enable = 1'b1;
         end
         OP_NOT: begin
            res.write_value = ~it.a;
            res.write_enable = 1'b1;
         end
         OP_RCL: begin
            res.write_value = {it.a[14:0], flag_c};
            flag_c = it.a[15];
            res.write_enable = 1'b1;
         end
         OP_RCR: begin
            res.write_value = {flag_c, it.a[15:1]};
            flag_c = it.a[0];
            res.write_enable = 1'b1;
         end
         OP_POP: begin
            stack_top--;
            res.write_value = stack_mem[stack_top];
            res.write_enable = 1'b1;
         end
         OP_PUSH: begin
            stack_mem[stack_top] = it.a;
            stack_top++;
         end
         OP_ADD, OP_ADC: begin
            wide = {1'b0, it.a} + {1'b0, it.b} +
                   {16'd0, (it.cmd == OP_ADC) ? flag_c : 1'b0};
            flag_c = wide[WORD_BITS];
            flag_z = (wide[WORD_BITS-1:0] == 16'd0);
            res.write_value = wide[WORD_BITS-1:0];
            res.write_enable = 1'b1;
         end
         OP_SUB, OP_SBB, OP_CMP: begin
            sub = {1'b0, it.b} + {16'd0, (it.cmd == OP_SBB) ? flag_c : 1'b0};
            flag_c = ({1'b0, it.a} < sub);
            r = it.a - sub[WORD_BITS-1:0];
            flag_z = (r == 16'd0);
            if (it.cmd != OP_CMP) begin
               res.write_value = r;
               res.write_enable = 1'b1;
            end
         end
         OP_MOV: begin
            res.write_value = it.b;
            res.write_enable = 1'b1;
         end
         OP_AND, OP_OR: begin
            r = (it.cmd == OP_AND) ? (it.a & it.b) : (it.a | it.b);
            flag_z = (r == 16'd0);
            flag_c = 1'b0;
            res.write_value = r;
            res.write_enable = 1'b1;
         end
         OP_CLC: flag_c = 1'b0;
         OP_STC: flag_c = 1'b1;
         OP_CMC: flag_c = ~flag_c;
         OP_JMP: nxt = it.tgt;
         OP_JZ:  if (flag_z) nxt = it.tgt;
         OP_JNZ: if (!flag_z) nxt = it.tgt;
         OP_JC:  if (flag_c) nxt = it.tgt;
         OP_JNC: if (!flag_c) nxt = it.tgt;
         OP_LOOP: begin
            res.count_out = it.cnt - 16'd1;
            res.count_write = 1'b1;
            if (res.count_out != 16'd0) nxt = it.tgt;
         end
         OP_CALL: begin
            stack_mem[stack_top] = nxt;
            stack_top++;
            nxt = it.tgt;
         end
         OP_RET: begin
            stack_top--;
            nxt = stack_mem[stack_top];
         end
         default: ;
      endcase
      res.carry = flag_c;
      res.zero  = flag_z;
      if (nxt >= prog_lines || nxt == 16'd0) begin
         res.next_line = it.line;
         res.status = ST_OUTSIDE;
      end else begin
         res.next_line = nxt;
      end
      return res;
   endfunction

   function automatic logic [WORD_BITS-1:0] rand_word();
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h8000;
         3: return 16'h7FFF;
         4: return 16'h0001;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic instr_type make_random(input logic [WORD_BITS-1:0] plines);
      instr_type it;
      if ($urandom_range(0, 99) < 88) it.cmd = 5'($urandom_range(1, 27));
      else it.cmd = 5'($urandom);
      it.a = rand_word();
      it.b = rand_word();
      if ($urandom_range(0, 3) == 0) it.cnt = 16'($urandom_range(0, 2));
      else it.cnt = 16'($urandom);
      if ($urandom_range(0, 4) == 0) it.tgt = 16'($urandom);
      else it.tgt = 16'($urandom_range(1, int'(plines) - 1));
      if ($urandom_range(0, 6) == 0) it.line = 16'($urandom);
      else it.line = 16'($urandom_range(0, int'(plines) - 2));
      return it;
   endfunction

   task automatic add_instr(input logic [CMD_BITS-1:0] cmd, input logic [WORD_BITS-1:0] a,
                            input logic [WORD_BITS-1:0] b, input logic [WORD_BITS-1:0] cnt,
                            input logic [WORD_BITS-1:0] tgt,
                            input logic [WORD_BITS-1:0] line);
      instr_type it;
      it.cmd = cmd;
      it.a = a;
      it.b = b;
      it.cnt = cnt;
      it.tgt = tgt;
      it.line = line;
      pending_instrs.push_back(it);
   endtask

   task automatic add_random(input int n);
      repeat (n) pending_instrs.push_back(make_random(prog_lines));
   endtask

   // fill past the top, then drain past the bottom
   task automatic add_stack_burst();
      instr_type it;
      for (int i = 0; i < 2 * (STACK_SLOTS + 3); i++) begin
         it = make_random(prog_lines);
         it.line = 16'($urandom_range(0, int'(prog_lines) - 2));
         if (i < STACK_SLOTS + 3) it.cmd = $urandom_range(0, 1) ? OP_PUSH : OP_CALL;
         else it.cmd = $urandom_range(0, 1) ? OP_POP : OP_RET;
         pending_instrs.push_back(it);
      end
   endtask

   task automatic wait_idle();
      while (!(pending_instrs.size() == 0 && issued == accepted &&
               expected_results.size() == 0))
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_prog_lines(input logic [WORD_BITS-1:0] value);
      wait_idle();
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      prog_lines = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      settings_run++;
   endtask

   // driver
   always @(posedge clock) begin
      tcx_result_type res;
      if (reset) begin
         req_if.valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            res = execute_instr(cur_instr);
            expected_results.push_back(res);
            status_seen[res.status]++;
            if (stack_top > stack_peak) stack_peak = stack_top;
            accepted++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_if.valid <= 1'b0;
            end else if (pending_instrs.size() > 0) begin
               cur_instr = pending_instrs.pop_front();
               req_if.cmd          <= cur_instr.cmd;
               req_if.operand_a    <= cur_instr.a;
               req_if.operand_b    <= cur_instr.b;
               req_if.count_value  <= cur_instr.cnt;
               req_if.jump_target  <= cur_instr.tgt;
               req_if.current_line <= cur_instr.line;
               req_if.valid        <= 1'b1;
               issued++;
               req_gap = pick_gap(req_quiet);
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      tcx_result_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_results.size() == 0) begin
               report_error("result transaction with no instruction outstanding");
            end else begin
               want = expected_results.pop_front();
               check_field("write_value", rsp_if.write_value, want.write_value);
               check_field("write_enable", WORD_BITS'(rsp_if.write_enable),
                           WORD_BITS'(want.write_enable));
               check_field("count_out", rsp_if.count_out, want.count_out);
               check_field("count_write", WORD_BITS'(rsp_if.count_write),
                           WORD_BITS'(want.count_write));
               check_field("next_line", rsp_if.next_line, want.next_line);
               check_field("carry_out", WORD_BITS'(rsp_if.carry_out), WORD_BITS'(want.carry));
               check_field("zero_out", WORD_BITS'(rsp_if.zero_out), WORD_BITS'(want.zero));
               check_field("status", WORD_BITS'(rsp_if.status), WORD_BITS'(want.status));
               checked++;
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) rsp_stall = pick_gap(rsp_quiet);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_results.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_if.valid = 1'b0;
      req_if.cmd = '0;
      req_if.operand_a = '0;
      req_if.operand_b = '0;
      req_if.count_value = '0;
      req_if.jump_target = '0;
      req_if.current_line = '0;
      rsp_if.ready = 1'b0;
      prog_lines = PROGRAM_LINES_RESET;
      flag_c = 1'b0;
      flag_z = 1'b0;
      stack_top = 0;
      stack_peak = 0;
      issued = 0;
      accepted = 0;
      checked = 0;
      err_count = 0;
      cycle_count = 0;
      settings_run = 1;
      req_quiet = 0;
      rsp_quiet = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed, at the reset program length
      add_instr(OP_RET,  16'h0000, 16'h0000, 16'h0000, 16'h0005, 16'h0000);
      add_instr(OP_POP,  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001);
      add_instr(OP_NOT,  16'h5A5A, 16'h0000, 16'h0000, 16'h0000, 16'h0002);
      add_instr(OP_NEG,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0003);
      add_instr(OP_NEG,  16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0004);
      add_instr(OP_DEC,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0005);
      add_instr(OP_INC,  16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0006);
      add_instr(OP_JZ,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0007);
      add_instr(OP_ADD,  16'hFFFF, 16'h0001, 16'h0000, 16'h0000, 16'h0008);
      add_instr(OP_JC,   16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'h0009);
      add_instr(OP_ADC,  16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h000A);
      add_instr(OP_SUB,  16'h0000, 16'h0001, 16'h0000, 16'h0000, 16'h000B);
      add_instr(OP_SBB,  16'h0005, 16'h0004, 16'h0000, 16'h0000, 16'h000C);
      add_instr(OP_JNZ,  16'h0000, 16'h0000, 16'h0000, 16'h0040, 16'h000D);
      add_instr(OP_CMP,  16'h0007, 16'h0007, 16'h0000, 16'h0000, 16'h000E);
      add_instr(OP_AND,  16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h000F);
      add_instr(OP_OR,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0010);
      add_instr(OP_MOV,  16'h1234, 16'hFFFF, 16'h0000, 16'h0000, 16'h0011);
      add_instr(OP_STC,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0012);
      add_instr(OP_RCL,  16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0013);
      add_instr(OP_RCR,  16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0014);
      add_instr(OP_CMC,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0015);
      add_instr(OP_CLC,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0016);
      add_instr(OP_JNC,  16'h0000, 16'h0000, 16'h0000, 16'h0064, 16'h0017);
      add_instr(OP_JMP,  16'h0000, 16'h0000, 16'h0000, 16'h00C8, 16'h0018);
      add_instr(OP_PUSH, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0019);
      add_instr(OP_POP,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h001A);
      add_instr(OP_CALL, 16'h0000, 16'h0000, 16'h0000, 16'h0032, 16'hFFFD);
      add_instr(OP_RET,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0032);
      add_instr(OP_LOOP, 16'h0000, 16'h0000, 16'h0001, 16'h001E, 16'h001B);
      add_instr(OP_LOOP, 16'h0000, 16'h0000, 16'h0000, 16'h001E, 16'h001C);
      add_instr(OP_LOOP, 16'h0000, 16'h0000, 16'hFFFF, 16'h001E, 16'h001D);
      add_instr(5'd0,    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h001E);
      add_instr(5'd31,   16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      add_instr(OP_MOV,  16'h0000, 16'h0001, 16'h0000, 16'h0000, 16'hFFFE);

      add_stack_burst();
      add_random(60);

      write_prog_lines(16'd2);
      add_random(50);

      write_prog_lines(16'd40);
      add_stack_burst();
      add_random(40);

      write_prog_lines(16'd300);
      add_random(60);

      write_prog_lines(16'hFFFF);
      add_random(40);

      wait_idle();
      if (expected_results.size() != 0)
         report_error($sformatf("%0d results never arrived", expected_results.size()));
      $display("Executed %0d instructions under %0d program lengths, %0d results checked",
               accepted, settings_run, checked);
      $display("Status mix: ok %0d, stack empty %0d, outside %0d, stack full %0d; peak depth %0d",
               status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_OUTSIDE],
               status_seen[ST_FULL], stack_peak);
      if (err_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches", err_count);
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

### filelist.f
hdl/tcx_pkg.sv
hdl/tcx_req_if.sv
hdl/tcx_rsp_if.sv
hdl/tcx_ram.sv
hdl/tcx_issue.sv
hdl/tcx_retire.sv
hdl/teaching_cpu_execute_unit.sv
verif/testbench.sv
